// ----- design/deq_pkg.sv -----
package deq_pkg;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd1;
	localparam logic [2:0] REQ_LIST       = 3'd2;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd3;
	localparam logic [2:0] REQ_POP_BACK   = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_LIST
	} state_t;

endpackage

// ----- design/deq_ram.sv -----
module deq_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/deq_ctrl.sv -----
module deq_ctrl
	import deq_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,
	input  logic [2:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic [1:0]    m_tuser,
	output logic          m_tlast,
	output logic          we,
	output logic [AW-1:0] waddr,
	output logic [31:0]   wdata,
	output logic          re,
	output logic [AW-1:0] raddr,
	input  logic [31:0]   rdata
);

	localparam int SW = CW + 1;

	state_t        state_q, state_d;
	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] occ_q, occ_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] rem_q, rem_d;

	logic          valid_s1, use_mem_s1, last_s1;
	logic [1:0]    status_s1;
	logic          load_s1, use_mem_d, last_d;
	logic [1:0]    status_d;

	logic          out_valid_q, last_q;
	logic [1:0]    status_q;
	logic [31:0]   data_q;

	logic          out_free, adv, acc, full, empty;
	logic [AW-1:0] front_inc, front_dec, back_pos, tail_pos;
	logic [SW-1:0] sum_back, sum_tail;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
		wrap_inc = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
		wrap_sum = (s >= SW'(DEPTH)) ? AW'(s - SW'(DEPTH)) : AW'(s);
	endfunction

	assign out_free  = !out_valid_q || m_tready;
	assign adv       = !valid_s1 || out_free;
	assign s_tready  = (state_q == ST_IDLE) && adv;
	assign acc       = s_tvalid && s_tready;
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign front_inc = wrap_inc(front_q);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign sum_back  = SW'(front_q) + SW'(occ_q);
	assign sum_tail  = sum_back - SW'(1);
	assign back_pos  = wrap_sum(sum_back);
	assign tail_pos  = wrap_sum(sum_tail);
	assign wdata     = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
			ptr_q   <= ptr_d;
			rem_q   <= rem_d;
			if (adv) begin
				valid_s1 <= load_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			use_mem_s1 <= use_mem_d;
			status_s1  <= status_d;
			last_s1    <= last_d;
		end
		if (out_free && valid_s1) begin
			data_q   <= use_mem_s1 ? rdata : '0;
			status_q <= status_s1;
			last_q   <= last_s1;
		end
	end

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		occ_d     = occ_q;
		ptr_d     = ptr_q;
		rem_d     = rem_q;
		we        = 1'b0;
		waddr     = back_pos;
		re        = 1'b0;
		raddr     = front_q;
		load_s1   = 1'b0;
		use_mem_d = 1'b0;
		status_d  = STAT_OK;
		last_d    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (s_tuser)
						REQ_PUSH_FRONT: begin
							load_s1 = 1'b1;
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = front_dec;
								front_d = front_dec;
								occ_d   = occ_q + CW'(1);
							end
						end
						REQ_PUSH_BACK: begin
							load_s1 = 1'b1;
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								we    = 1'b1;
								occ_d = occ_q + CW'(1);
							end
						end
						REQ_POP_FRONT: begin
							load_s1 = 1'b1;
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								re        = 1'b1;
								use_mem_d = 1'b1;
								front_d   = front_inc;
								occ_d     = occ_q - CW'(1);
							end
						end
						REQ_POP_BACK: begin
							load_s1 = 1'b1;
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								re        = 1'b1;
								raddr     = tail_pos;
								use_mem_d = 1'b1;
								occ_d     = occ_q - CW'(1);
							end
						end
						REQ_LIST: begin
							load_s1 = 1'b1;
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								re        = 1'b1;
								use_mem_d = 1'b1;
								last_d    = (occ_q == CW'(1));
								if (occ_q != CW'(1)) begin
									state_d = ST_LIST;
									ptr_d   = front_inc;
									rem_d   = occ_q - CW'(1);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_LIST: begin
				if (adv) begin
					re        = 1'b1;
					raddr     = ptr_q;
					load_s1   = 1'b1;
					use_mem_d = 1'b1;
					last_d    = (rem_q == CW'(1));
					ptr_d     = wrap_inc(ptr_q);
					rem_d     = rem_q - CW'(1);
					if (rem_q == CW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule

// ----- design/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// entries in one synchronous memory. A push or a pop gives one word through the
// stage-1 and output registers; back-to-back pushes and pops run at one word
// per cycle while the output is not stalled. A list request of n stored words
// holds off input until all n are read through the single memory read port and
// gives them front to back with tlast on the final one. Empty and full are
// reported in tuser; no clearing pass is needed after reset.
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // word[31:0]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	deq_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr   (raddr),
		.rdata   (rdata)
	);

	deq_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import deq_pkg::*;

	localparam int RING_DEPTH = 64;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  status;
		logic        last;
	} deq_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	logic [31:0] ring_mem [RING_DEPTH];
	logic [5:0]  ring_head = '0;
	logic [6:0]  ring_count = '0;
	deq_word_t   expected_words [$];

	int          fail_count = 0;
	bit          tx_gaps_on = 1'b1;
	int          tx_burst_left = 0;
	int          rx_mode = 0;
	int          rx_hold_left = 0;
	logic [15:0] rx_pattern = 16'hffff;
	logic [3:0]  rx_phase = '0;

	double_ended_queue #(.DEPTH(RING_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),  // value[31:0]
		.s_tuser  (s_tuser),  // req_type[2:0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),  // word[31:0]
		.m_tuser  (m_tuser),  // status[1:0]
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic push_expected(input logic [31:0] word, input logic [1:0] status,
		input logic last);
		deq_word_t w;
		w.word = word;
		w.status = status;
		w.last = last;
		expected_words.push_back(w);
	endtask

	task automatic predict_request(input logic [2:0] req, input logic [31:0] val);
		logic [5:0] idx;
		case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (ring_count == RING_DEPTH) begin
					push_expected('0, STAT_FULL, 1'b1);
				end else begin
					if (req == REQ_PUSH_FRONT) begin
						ring_head = ring_head - 6'd1;
						idx = ring_head;
					end else begin
						idx = ring_head + ring_count[5:0];
					end
					ring_mem[idx] = val;
					ring_count++;
					push_expected('0, STAT_OK, 1'b1);
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (ring_count == 0) begin
					push_expected('0, STAT_EMPTY, 1'b1);
				end else if (req == REQ_POP_FRONT) begin
					push_expected(ring_mem[ring_head], STAT_OK, 1'b1);
					ring_head = ring_head + 6'd1;
					ring_count--;
				end else begin
					idx = ring_head + ring_count[5:0] - 6'd1;
					push_expected(ring_mem[idx], STAT_OK, 1'b1);
					ring_count--;
				end
			end
			REQ_LIST: begin
				if (ring_count == 0) begin
					push_expected('0, STAT_EMPTY, 1'b1);
				end else begin
					for (int k = 0; k < ring_count; k++) begin
						idx = ring_head + k[5:0];
						push_expected(ring_mem[idx], STAT_OK, (k + 1 == ring_count));
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [2:0] req, input logic [31:0] val);
		int gap;
		if (tx_gaps_on && tx_burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
			tx_burst_left = $urandom_range(1, 30);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= req;
		do @(posedge clk); while (!s_tready);
		predict_request(req, val);
		if (tx_burst_left > 0)
			tx_burst_left--;
	endtask

	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 99) < 60);
				default: begin
					m_tready <= rx_pattern[rx_phase];
					rx_phase <= rx_phase + 4'd1;
					if (rx_phase == 4'd15) begin
						rx_pattern[15:0] <= 16'($urandom) | 16'(16'd1 << $urandom_range(0, 15));
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		deq_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word %h status %0d last %0b", m_tdata, m_tuser, m_tlast);
				fail_count++;
			end else begin
				w = expected_words.pop_front();
				if (m_tdata !== w.word) begin
					$error("word: expected %h, got %h", w.word, m_tdata);
					fail_count++;
				end
				if (m_tuser !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, m_tuser);
					fail_count++;
				end
				if (m_tlast !== w.last) begin
					$error("last: expected %0b, got %0b", w.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	task automatic test_corner_requests();
		rx_mode = 2;
		tx_gaps_on = 1'b1;
		send_item(REQ_POP_FRONT, $urandom);
		send_item(REQ_POP_BACK, $urandom);
		send_item(REQ_LIST, $urandom);
		send_item(3'd5, $urandom);
		send_item(3'd6, $urandom);
		send_item(3'd7, $urandom);
		send_item(REQ_PUSH_FRONT, 32'h8000_0000);
		send_item(REQ_POP_FRONT, $urandom);
		send_item(REQ_PUSH_BACK, 32'h7fff_ffff);
		send_item(REQ_POP_BACK, $urandom);
		send_item(REQ_PUSH_FRONT, 32'hffff_ffff);
		send_item(REQ_PUSH_BACK, 32'h0000_0000);
		send_item(REQ_PUSH_FRONT, 32'h0000_0001);
		send_item(REQ_PUSH_BACK, 32'ha5a5_5a5a);
		send_item(REQ_LIST, $urandom);
		send_item(REQ_POP_BACK, $urandom);
		send_item(REQ_POP_FRONT, $urandom);
		send_item(REQ_POP_FRONT, $urandom);
		send_item(REQ_POP_BACK, $urandom);
		send_item(REQ_POP_FRONT, $urandom);
		send_item(REQ_LIST, $urandom);
	endtask

	task automatic test_full_ring();
		rx_mode = 0;
		tx_gaps_on = 1'b0;
		while (ring_count < RING_DEPTH)
			send_item($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom);
		send_item(REQ_PUSH_FRONT, $urandom);
		send_item(REQ_PUSH_BACK, $urandom);
		send_item(REQ_LIST, $urandom);
		rx_mode = 1;
		while (ring_count > 0) begin
			if (ring_count == RING_DEPTH / 2)
				send_item(REQ_LIST, $urandom);
			send_item($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, $urandom);
		end
		send_item(REQ_LIST, $urandom);
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		rx_mode = 0;
		tx_gaps_on = 1'b0;
		rx_hold_left = 400;
		repeat (20) send_item(REQ_PUSH_BACK, $urandom);
		send_item(REQ_LIST, $urandom);
		repeat (10) send_item(REQ_PUSH_FRONT, $urandom);
		send_item(REQ_LIST, $urandom);
		repeat (30) send_item(REQ_POP_FRONT, $urandom);
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_mix(input int n_items);
		int done;
		int phase_left;
		int push_share;
		int r;
		logic [2:0]  req;
		logic [31:0] val;
		done = 0;
		phase_left = 0;
		push_share = 60;
		while (done < n_items) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 70);
				push_share = (push_share == 60) ? 25 : 60;
				rx_mode = $urandom_range(0, 2);
				tx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			if (r < 3)
				req = 3'($urandom_range(5, 7));
			else if (r < 10)
				req = REQ_LIST;
			else if (r < 10 + push_share)
				req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			else
				req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
			case ($urandom_range(0, 9))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
				default: val = $urandom;
			endcase
			send_item(req, val);
			if (req <= REQ_POP_BACK) begin
				done++;
				phase_left--;
			end
		end
	endtask

	initial begin
		int guard;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_requests();
		test_full_ring();
		test_output_backpressure();
		test_random_mix(100);
		s_tvalid <= 1'b0;
		rx_mode = 1;
		guard = 0;
		while (expected_words.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d words never arrived", expected_words.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
bench/tb.sv
